// ----- design/self_organizing_list_assert.svh -----
// ----------------------------------------------------------------------------
// Self-organizing list assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SELF_ORGANIZING_LIST_ASSERT_SVH
`define SELF_ORGANIZING_LIST_ASSERT_SVH

// Same-cycle implication
`define SOL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("self_organizing_list check failed");

// Next-cycle implication
`define SOL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("self_organizing_list check failed");

`endif

// ----- design/sol_pkg.sv -----
// ----------------------------------------------------------------------------
// sol_pkg
// Shared codes, types and defaults of the self-organizing list.
// ----------------------------------------------------------------------------
package sol_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int KEY_WIDTH_DEF  = 16;

    // Widest position and count over the supported depth range (up to 256)
    localparam int MAX_POS_W = 8;
    localparam int MAX_CNT_W = 9;

    localparam int IN_W  = 24;
    localparam int OUT_W = 16;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_MTF    = 2'd1,
        FUNC_SWAP   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_MTF    = 2'd2,
        CMD_SWAP   = 2'd3
    } cmd_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [MAX_POS_W-1:0] pos;
        logic [MAX_CNT_W-1:0] count;
    } cell_ctrl_t;

endpackage

// ----- design/sol_cell.sv -----
// ----------------------------------------------------------------------------
// sol_cell
// One list slot: holds a key, compares it and trades it with its neighbors.
// ----------------------------------------------------------------------------
module sol_cell #(
    parameter int KEY_WIDTH  = sol_pkg::KEY_WIDTH_DEF,
    parameter int CELL_INDEX = 0
) (
    input  logic                   clk,
    input  sol_pkg::cell_ctrl_t    ctrl,
    input  logic [KEY_WIDTH-1:0]   key,
    input  logic [KEY_WIDTH-1:0]   prev_key,
    input  logic [KEY_WIDTH-1:0]   next_key,
    input  logic                   next_hit,
    output logic [KEY_WIDTH-1:0]   cell_key,
    output logic                   hit
);

    localparam logic [sol_pkg::MAX_CNT_W-1:0] IDX_C = sol_pkg::MAX_CNT_W'(CELL_INDEX);
    localparam logic [sol_pkg::MAX_POS_W-1:0] IDX_P = sol_pkg::MAX_POS_W'(CELL_INDEX);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;

    assign cell_key = key_reg;
    assign hit      = (IDX_C < ctrl.count) && (key_reg == key);

    always_comb
    begin
        key_next = key_reg;
        unique case (ctrl.cmd)
            sol_pkg::CMD_INSERT:
            begin
                if (IDX_C == ctrl.count)
                    key_next = key;
            end
            sol_pkg::CMD_MTF:
            begin
                // head takes the key, cells up to the hit shift back by one
                if (CELL_INDEX == 0)
                    key_next = key;
                else if (IDX_P <= ctrl.pos)
                    key_next = prev_key;
            end
            sol_pkg::CMD_SWAP:
            begin
                if (next_hit)
                    key_next = next_key;
                else if (hit)
                    key_next = prev_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ----- design/sol_encoder.sv -----
// ----------------------------------------------------------------------------
// sol_encoder
// Turns the one-hot hit vector of the cell row into a position and a flag.
// ----------------------------------------------------------------------------
module sol_encoder #(
    parameter int LIST_DEPTH = sol_pkg::LIST_DEPTH_DEF
) (
    input  logic [LIST_DEPTH-1:0]         hit,
    output logic [$clog2(LIST_DEPTH)-1:0] pos,
    output logic                          found
);

    localparam int PW = $clog2(LIST_DEPTH);

    assign found = |hit;

    // keys are distinct, so at most one bit is set and an OR per bit suffices
    always_comb
    begin
        pos = '0;
        for (int b = 0; b < PW; b++)
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                if (((i >> b) & 1) == 1)
                    pos[b] = pos[b] | hit[i];
            end
        end
    end

endmodule

// ----- design/self_organizing_list.sv -----
// ----------------------------------------------------------------------------
// self_organizing_list
// Ordered key list with insert, move-to-front search and transpose search.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  s_      | in        | tdata: func[1:0], key[17:2]
//  m_      | out       | tdata: status[1:0], found_position[5:2], entry_count[10:6]
//
//  Each item is captured in the idle state; in the execute state every cell
//  compares its key at once and the row shifts or swaps in one step.
//  Reset empties the list by clearing the count; no clearing pass is needed.
//  The execute cycle waits while the output register holds an untaken result.
// ----------------------------------------------------------------------------
`include "self_organizing_list_assert.svh"

module self_organizing_list #(
    parameter int LIST_DEPTH = sol_pkg::LIST_DEPTH_DEF,
    parameter int KEY_WIDTH  = sol_pkg::KEY_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [sol_pkg::IN_W-1:0]  s_tdata,   // func[1:0], key[17:2], zero pad
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [sol_pkg::OUT_W-1:0] m_tdata    // status[1:0], found_position[5:2],
                                                 // entry_count[10:6], zero pad
);

    localparam int PW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    sol_pkg::state_t  state_reg, state_next;
    sol_pkg::func_t   func_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             m_valid_reg;
    sol_pkg::status_t status_reg;
    logic [3:0]       pos_out_reg;
    logic [4:0]       count_out_reg;

    logic             accept;
    logic             go;
    logic [LIST_DEPTH-1:0] hit;
    logic [KEY_WIDTH-1:0]  cell_key [LIST_DEPTH];
    logic [PW-1:0]    hit_pos;
    logic             found;
    sol_pkg::cmd_t    cmd;
    sol_pkg::status_t status;
    logic [CW-1:0]    res_pos;
    sol_pkg::cell_ctrl_t ctrl;

    assign accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        go         = 1'b0;
        unique case (state_reg)
            sol_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = sol_pkg::S_EXEC;
            end
            sol_pkg::S_EXEC:
            begin
                go = !m_valid_reg || m_tready;
                if (go)
                    state_next = sol_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sol_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sol_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= sol_pkg::func_t'(s_tdata[1:0]);
            key_reg  <= KEY_WIDTH'(s_tdata[17:2]);
        end
    end

    // ------------------------------------------------------------------
    // Operation decode
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd        = sol_pkg::CMD_NONE;
        status     = sol_pkg::ST_NOT_FOUND;
        res_pos    = '0;
        count_next = count_reg;
        unique case (func_reg)
            sol_pkg::FUNC_INSERT:
            begin
                if (found)
                    status = sol_pkg::ST_DUPLICATE;
                else if (count_reg == CW'(LIST_DEPTH))
                    status = sol_pkg::ST_FULL;
                else
                begin
                    status     = sol_pkg::ST_OK;
                    res_pos    = count_reg;
                    cmd        = sol_pkg::CMD_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            sol_pkg::FUNC_MTF:
            begin
                if (found)
                begin
                    status  = sol_pkg::ST_OK;
                    res_pos = CW'(hit_pos);
                    cmd     = sol_pkg::CMD_MTF;
                end
            end
            sol_pkg::FUNC_SWAP:
            begin
                if (found)
                begin
                    status  = sol_pkg::ST_OK;
                    res_pos = CW'(hit_pos);
                    if (hit_pos != '0)
                        cmd = sol_pkg::CMD_SWAP;
                end
            end
            default:
            begin
                status = sol_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    assign ctrl.cmd   = go ? cmd : sol_pkg::CMD_NONE;
    assign ctrl.pos   = sol_pkg::MAX_POS_W'(hit_pos);
    assign ctrl.count = sol_pkg::MAX_CNT_W'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (go)
            count_reg <= count_next;
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] prev_key;
        logic [KEY_WIDTH-1:0] next_key;
        logic                 next_hit;

        if (i == 0)
        begin : g_first
            assign prev_key = '0;
        end
        else
        begin : g_mid
            assign prev_key = cell_key[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign next_key = '0;
            assign next_hit = 1'b0;
        end
        else
        begin : g_body
            assign next_key = cell_key[i+1];
            assign next_hit = hit[i+1];
        end

        sol_cell #(
            .KEY_WIDTH  (KEY_WIDTH),
            .CELL_INDEX (i)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .key      (key_reg),
            .prev_key (prev_key),
            .next_key (next_key),
            .next_hit (next_hit),
            .cell_key (cell_key[i]),
            .hit      (hit[i])
        );
    end

    sol_encoder #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_encoder (
        .hit   (hit),
        .pos   (hit_pos),
        .found (found)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (go)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            status_reg    <= status;
            pos_out_reg   <= 4'(res_pos);
            count_out_reg <= 5'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, count_out_reg, pos_out_reg, status_reg};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SOL_ASSERT_NOW(a_hit_unique, 1'b1, $onehot0(hit))
    `SOL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(LIST_DEPTH))
    `SOL_ASSERT_NEXT(a_insert_grows, ctrl.cmd == sol_pkg::CMD_INSERT,
        count_reg == $past(count_reg) + 1'b1)
    `SOL_ASSERT_NEXT(a_result_follows, go, m_valid_reg && state_reg == sol_pkg::S_IDLE)

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for self_organizing_list. A scoreboard keeps its own
// copy of the key list, predicts status, position and count for every
// accepted transaction and compares results in order. Directed cases cover
// the empty, head, tail, duplicate and full-list corners. Random traffic
// draws most keys from a small pool so that searches hit and the list fills.
// Both sides insert random idle bursts, and one long output stall backs the
// block up.
// ----------------------------------------------------------------------------
module tb;
    import sol_pkg::*;

    localparam logic [1:0] FUNC_UNDEF = 2'd3;
    localparam int         DEPTH      = LIST_DEPTH_DEF;
    localparam int         RAND_ITEMS = 400;
    localparam int         QUIET_FROM = 330;
    localparam int         LONG_HOLD  = 80;
    localparam int         HOLD_AT    = 150;
    localparam int         POOL_SIZE  = 24;

    typedef struct packed {
        status_t     status;
        logic [3:0]  pos;
        logic [4:0]  count;
    } outcome_t;

    class list_scoreboard;
        logic [15:0] keys [DEPTH];
        int unsigned count;
        outcome_t    outcome_q [$];
        int unsigned errors;
        int unsigned results;
        int unsigned op_seen [4];
        int unsigned hits;
        int unsigned misses;
        int unsigned dups;
        int unsigned fulls;

        function int locate(logic [15:0] key);
            for (int i = 0; i < count; i++)
                if (keys[i] === key)
                    return i;
            return -1;
        endfunction

        // Update the list copy and return what the block should report
        function outcome_t compute_outcome(logic [1:0] func, logic [15:0] key);
            outcome_t    o;
            int          idx;
            logic [15:0] tmp;
            o.status = ST_NOT_FOUND;
            o.pos    = '0;
            idx      = locate(key);
            if (func == FUNC_INSERT) begin
                if (idx >= 0) begin
                    o.status = ST_DUPLICATE;
                end
                else if (count >= DEPTH) begin
                    o.status = ST_FULL;
                end
                else begin
                    keys[count] = key;
                    o.pos       = count[3:0];
                    count++;
                    o.status    = ST_OK;
                end
            end
            else if (func == FUNC_MTF || func == FUNC_SWAP) begin
                if (idx >= 0) begin
                    o.status = ST_OK;
                    o.pos    = idx[3:0];
                    if (func == FUNC_MTF) begin
                        for (int i = idx; i > 0; i--)
                            keys[i] = keys[i-1];
                        keys[0] = key;
                    end
                    else if (idx > 0) begin
                        tmp         = keys[idx-1];
                        keys[idx-1] = keys[idx];
                        keys[idx]   = tmp;
                    end
                end
            end
            o.count = count[4:0];
            return o;
        endfunction

        function void note_request(logic [1:0] func, logic [15:0] key);
            outcome_t o;
            o = compute_outcome(func, key);
            op_seen[func]++;
            if (func != FUNC_INSERT && func != FUNC_UNDEF) begin
                if (o.status == ST_OK)
                    hits++;
                else
                    misses++;
            end
            if (o.status == ST_DUPLICATE)
                dups++;
            if (o.status == ST_FULL)
                fulls++;
            outcome_q.push_back(o);
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            outcome_t want;
            results++;
            if (outcome_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result tdata=%h", data);
                return;
            end
            want = outcome_q.pop_front();
            if (data[1:0] !== want.status || data[5:2] !== want.pos
                    || data[10:6] !== want.count) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d: status %0d/%0d pos %0d/%0d count %0d/%0d (exp/act)",
                             results, want.status, data[1:0], want.pos, data[5:2],
                             want.count, data[10:6]);
            end
        endfunction
    endclass

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [IN_W-1:0]     s_tdata  = '0;
    logic                m_tready = 1'b0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire  [OUT_W-1:0]    m_tdata;
    bit                  quiet    = 1'b0;
    list_scoreboard      sb       = new();

    self_organizing_list dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #200000;
        $display("== FAIL ==");
        $finish;
    end

    // Offer one transaction and hold it until the block takes it
    task automatic send_op(input logic [1:0] func, input logic [15:0] key);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, key, func};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(func, key);
    endtask

    // Result side: random short stalls plus one long hold
    initial
    begin
        int  stall_left;
        bit  held;
        stall_left = 0;
        held       = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!held && sb.results >= HOLD_AT) begin
                held       = 1'b1;
                stall_left = LONG_HOLD - 1;
                m_tready   <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                m_tready   <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [15:0] pool [POOL_SIZE];
        logic [1:0]  func;
        logic [15:0] key;
        int unsigned roll;

        foreach (pool[i])
            pool[i] = $urandom_range(0, 65535);
        wait (rst_n);
        @(posedge clk);

        // Empty list, undefined op, extremes, duplicate, head and swap cases
        send_op(FUNC_MTF,    16'hFFFF);
        send_op(FUNC_SWAP,   16'h0000);
        send_op(FUNC_UNDEF,  16'h1234);
        send_op(FUNC_INSERT, 16'h0000);
        send_op(FUNC_INSERT, 16'hFFFF);
        send_op(FUNC_INSERT, 16'hFFFF);
        send_op(FUNC_MTF,    16'hFFFF);
        send_op(FUNC_SWAP,   16'h0000);
        send_op(FUNC_MTF,    16'h0000);
        send_op(FUNC_SWAP,   16'h0000);
        send_op(FUNC_INSERT, 16'hAAAA);
        send_op(FUNC_INSERT, 16'h5555);
        send_op(FUNC_MTF,    16'h5555);
        send_op(FUNC_SWAP,   16'hAAAA);
        send_op(FUNC_MTF,    16'h1234);
        send_op(FUNC_SWAP,   16'h4321);
        send_op(FUNC_UNDEF,  16'hFFFF);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n >= QUIET_FROM)
                quiet = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                func = FUNC_UNDEF;
            else if (roll < 40)
                func = FUNC_INSERT;
            else if (roll < 70)
                func = FUNC_MTF;
            else
                func = FUNC_SWAP;
            if ($urandom_range(0, 99) < 85)
                key = pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                key = $urandom_range(0, 65535);
            send_op(func, key);
        end

        // Fill up, then the full-list corners
        while (sb.count < DEPTH) begin
            key = $urandom_range(0, 65535);
            if (sb.locate(key) < 0)
                send_op(FUNC_INSERT, key);
        end
        do
            key = $urandom_range(0, 65535);
        while (sb.locate(key) >= 0);
        send_op(FUNC_INSERT, key);
        send_op(FUNC_INSERT, sb.keys[DEPTH-1]);
        send_op(FUNC_MTF,    sb.keys[DEPTH-1]);
        send_op(FUNC_SWAP,   sb.keys[DEPTH-1]);
        send_op(FUNC_SWAP,   sb.keys[0]);
        send_op(FUNC_UNDEF,  sb.keys[3]);
        s_tvalid <= 1'b0;

        while (sb.outcome_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d inserts, %0d move-to-front and %0d transpose searches, %0d undefined ops",
                 sb.op_seen[FUNC_INSERT], sb.op_seen[FUNC_MTF], sb.op_seen[FUNC_SWAP],
                 sb.op_seen[FUNC_UNDEF]);
        $display("Saw %0d hits, %0d misses, %0d duplicates, %0d full rejections, %0d errors",
                 sb.hits, sb.misses, sb.dups, sb.fulls, sb.errors);
        if (sb.errors == 0 && sb.outcome_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
